### hdl/stnh_pkg.sv
package stnh_pkg;

    localparam int CoordBitsDefault = 16;
    localparam int TBitsDefault     = 16;
    localparam int NumRegs          = 6;
    localparam int MacSteps         = 24;
    localparam int StepBits         = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_UPD
    } state_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_NX,
        DST_NY,
        DST_NZ,
        DST_D,
        DST_T,
        DST_EX,
        DST_EY,
        DST_EZ,
        DST_V,
        DST_W
    } dest_t;

    typedef struct packed {
        logic                load;
        logic                mac;
        logic [StepBits-1:0] step;
        logic                div_init;
        logic                div_step;
        logic                update;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

endpackage

### hdl/stnh_tri_if.sv
interface stnh_tri_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] corner_a_x;
    logic signed [COORD_BITS-1:0] corner_a_y;
    logic signed [COORD_BITS-1:0] corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x;
    logic signed [COORD_BITS-1:0] corner_b_y;
    logic signed [COORD_BITS-1:0] corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x;
    logic signed [COORD_BITS-1:0] corner_c_y;
    logic signed [COORD_BITS-1:0] corner_c_z;
    logic                         last_triangle;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, last_triangle,
        output ready
    );
endinterface

### hdl/stnh_res_if.sv
interface stnh_res_if #(
    parameter int T_BITS = 16
);
    logic            valid;
    logic            ready;
    logic            hit;
    logic [T_BITS:0] nearest_fraction;

    modport source (output valid, hit, nearest_fraction, input ready);
    modport sink (input valid, hit, nearest_fraction, output ready);
endinterface

### hdl/stnh_regs.sv
module stnh_regs #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [COORD_BITS-1:0] seg_reg [stnh_pkg::NumRegs]
);
    import stnh_pkg::*;

    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumRegs; i++)
            begin
                seg_reg[i] <= '0;
            end
        end
        else if (wr_en && (32'(idx) < NumRegs))
        begin
            seg_reg[idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (32'(idx) < NumRegs)
        begin
            prdata = 32'(seg_reg[idx]);
        end
    end
endmodule

### hdl/stnh_ctrl.sv
module stnh_ctrl #(
    parameter int T_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stnh_pkg::status_t stat,
    output stnh_pkg::cmd_t    cmd
);
    import stnh_pkg::*;

    localparam int CntBits = $clog2(T_BITS + 1);

    state_t              state_reg, state_next;
    logic [StepBits-1:0] step_reg, step_next;
    logic [CntBits-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == StepBits'(MacSteps - 1))
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntBits'(T_BITS - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // on the last triangle, hold while the previous result transaction is still pending
                if (!(stat.last && stat.out_busy))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.step = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MAC:
            begin
                cmd.mac      = 1'b1;
                cmd.div_init = (step_reg == StepBits'(MacSteps - 1));
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_UPD:
            begin
                cmd.update = !(stat.last && stat.out_busy);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule

### hdl/stnh_dp.sv
module stnh_dp #(
    parameter int COORD_BITS = 16,
    parameter int T_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COORD_BITS-1:0] seg_reg [stnh_pkg::NumRegs],
    stnh_tri_if.sink              triangle,
    stnh_res_if.source            result,
    input  stnh_pkg::cmd_t        cmd,
    output stnh_pkg::status_t     stat
);
    import stnh_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW + 1;
    localparam int AW = DW + PW + 3;

    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic signed [DW-1:0] qp_reg [3];
    logic signed [DW-1:0] ap_reg [3];
    logic signed [PW-1:0] n_reg  [3];
    logic signed [PW-1:0] e_reg  [3];
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] d_reg, t_reg, v_reg, w_reg;
    logic                 last_reg;
    logic [AW:0]          rem_reg;
    logic [T_BITS-1:0]    quo_reg;
    logic                 best_any_reg;
    logic [T_BITS:0]      best_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [T_BITS:0]      out_frac_reg;

    logic signed [DW-1:0]    op_a;
    logic signed [PW-1:0]    op_b;
    logic signed [DW+PW-1:0] prod;
    logic signed [AW-1:0]    acc_base;
    logic                    first;
    logic                    sub;
    dest_t                   dest;
    logic [AW:0]             rem_sh;
    logic [AW:0]             d_ext;
    logic                    tri_hit;
    logic [T_BITS:0]         frac;
    logic                    any_next;
    logic [T_BITS:0]         best_next;

    function automatic logic signed [DW-1:0] dif(input logic [COORD_BITS-1:0] x,
                                                 input logic [COORD_BITS-1:0] y);
        return DW'($signed(x)) - DW'($signed(y));
    endfunction

    // multiply-accumulate schedule: normal, d, t, cross(qp, ap), v, w
    always_comb
    begin
        op_a  = ab_reg[1];
        op_b  = PW'(ac_reg[2]);
        first = 1'b0;
        sub   = 1'b0;
        dest  = DST_NONE;
        case (cmd.step)
            5'd0:  begin op_a = ab_reg[1]; op_b = PW'(ac_reg[2]); first = 1'b1; end
            5'd1:  begin op_a = ab_reg[2]; op_b = PW'(ac_reg[1]); sub = 1'b1; dest = DST_NX; end
            5'd2:  begin op_a = ab_reg[2]; op_b = PW'(ac_reg[0]); first = 1'b1; end
            5'd3:  begin op_a = ab_reg[0]; op_b = PW'(ac_reg[2]); sub = 1'b1; dest = DST_NY; end
            5'd4:  begin op_a = ab_reg[0]; op_b = PW'(ac_reg[1]); first = 1'b1; end
            5'd5:  begin op_a = ab_reg[1]; op_b = PW'(ac_reg[0]); sub = 1'b1; dest = DST_NZ; end
            5'd6:  begin op_a = qp_reg[0]; op_b = n_reg[0]; first = 1'b1; end
            5'd7:  begin op_a = qp_reg[1]; op_b = n_reg[1]; end
            5'd8:  begin op_a = qp_reg[2]; op_b = n_reg[2]; dest = DST_D; end
            5'd9:  begin op_a = ap_reg[0]; op_b = n_reg[0]; first = 1'b1; end
            5'd10: begin op_a = ap_reg[1]; op_b = n_reg[1]; end
            5'd11: begin op_a = ap_reg[2]; op_b = n_reg[2]; dest = DST_T; end
            5'd12: begin op_a = qp_reg[1]; op_b = PW'(ap_reg[2]); first = 1'b1; end
            5'd13: begin op_a = qp_reg[2]; op_b = PW'(ap_reg[1]); sub = 1'b1; dest = DST_EX; end
            5'd14: begin op_a = qp_reg[2]; op_b = PW'(ap_reg[0]); first = 1'b1; end
            5'd15: begin op_a = qp_reg[0]; op_b = PW'(ap_reg[2]); sub = 1'b1; dest = DST_EY; end
            5'd16: begin op_a = qp_reg[0]; op_b = PW'(ap_reg[1]); first = 1'b1; end
            5'd17: begin op_a = qp_reg[1]; op_b = PW'(ap_reg[0]); sub = 1'b1; dest = DST_EZ; end
            5'd18: begin op_a = ac_reg[0]; op_b = e_reg[0]; first = 1'b1; end
            5'd19: begin op_a = ac_reg[1]; op_b = e_reg[1]; end
            5'd20: begin op_a = ac_reg[2]; op_b = e_reg[2]; dest = DST_V; end
            5'd21: begin op_a = ab_reg[0]; op_b = e_reg[0]; first = 1'b1; sub = 1'b1; end
            5'd22: begin op_a = ab_reg[1]; op_b = e_reg[1]; sub = 1'b1; end
            5'd23: begin op_a = ab_reg[2]; op_b = e_reg[2]; sub = 1'b1; dest = DST_W; end
            default: begin dest = DST_NONE; end
        endcase
    end

    assign prod     = op_a * op_b;
    assign acc_base = first ? '0 : acc_reg;
    assign acc_next = sub ? (acc_base - AW'(prod)) : (acc_base + AW'(prod));

    assign rem_sh = {rem_reg[AW-1:0], 1'b0};
    assign d_ext  = {1'b0, d_reg};

    assign tri_hit = (d_reg > 0) && (t_reg >= 0) && (t_reg <= d_reg)
                  && (v_reg >= 0) && (v_reg <= d_reg) && (w_reg >= 0)
                  && ((v_reg + w_reg) <= d_reg);
    assign frac      = (t_reg >= d_reg) ? {1'b1, T_BITS'(0)} : {1'b0, quo_reg};
    assign any_next  = best_any_reg || tri_hit;
    assign best_next = (tri_hit && (frac < best_reg)) ? frac : best_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ab_reg[0] <= DW'(triangle.corner_b_x) - DW'(triangle.corner_a_x);
            ab_reg[1] <= DW'(triangle.corner_b_y) - DW'(triangle.corner_a_y);
            ab_reg[2] <= DW'(triangle.corner_b_z) - DW'(triangle.corner_a_z);
            ac_reg[0] <= DW'(triangle.corner_c_x) - DW'(triangle.corner_a_x);
            ac_reg[1] <= DW'(triangle.corner_c_y) - DW'(triangle.corner_a_y);
            ac_reg[2] <= DW'(triangle.corner_c_z) - DW'(triangle.corner_a_z);
            qp_reg[0] <= dif(seg_reg[0], seg_reg[3]);
            qp_reg[1] <= dif(seg_reg[1], seg_reg[4]);
            qp_reg[2] <= dif(seg_reg[2], seg_reg[5]);
            ap_reg[0] <= DW'($signed(seg_reg[0])) - DW'(triangle.corner_a_x);
            ap_reg[1] <= DW'($signed(seg_reg[1])) - DW'(triangle.corner_a_y);
            ap_reg[2] <= DW'($signed(seg_reg[2])) - DW'(triangle.corner_a_z);
            last_reg  <= triangle.last_triangle;
        end
        if (cmd.mac)
        begin
            acc_reg <= acc_next;
            case (dest)
                DST_NX:  n_reg[0] <= PW'(acc_next);
                DST_NY:  n_reg[1] <= PW'(acc_next);
                DST_NZ:  n_reg[2] <= PW'(acc_next);
                DST_D:   d_reg    <= acc_next;
                DST_T:   t_reg    <= acc_next;
                DST_EX:  e_reg[0] <= PW'(acc_next);
                DST_EY:  e_reg[1] <= PW'(acc_next);
                DST_EZ:  e_reg[2] <= PW'(acc_next);
                DST_V:   v_reg    <= acc_next;
                DST_W:   w_reg    <= acc_next;
                default:
                begin
                end
            endcase
        end
        if (cmd.div_init)
        begin
            rem_reg <= {1'b0, t_reg};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            // restoring division: one quotient bit per cycle
            if (rem_sh >= d_ext)
            begin
                rem_reg <= rem_sh - d_ext;
                quo_reg <= {quo_reg[T_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[T_BITS-2:0], 1'b0};
            end
        end
        if (cmd.update && last_reg)
        begin
            out_hit_reg  <= any_next;
            out_frac_reg <= best_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_any_reg  <= 1'b0;
            best_reg      <= {1'b1, T_BITS'(0)};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (last_reg)
                begin
                    best_any_reg  <= 1'b0;
                    best_reg      <= {1'b1, T_BITS'(0)};
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    best_any_reg <= any_next;
                    best_reg     <= best_next;
                    if (result.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.hit              = out_hit_reg;
    assign result.nearest_fraction = out_frac_reg;

    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && !result.ready;
endmodule

### hdl/segment_triangle_nearest_hit_core.sv
// Each triangle passes an accept state, the multiply-accumulate steps on the shared
// multiplier, the bit-serial divide and an update state, in that order.
// A new triangle is accepted only once the current one has left the update state;
// results leave through an output register.
// Reset (rst_n, asynchronous, active low) clears segment registers, the running
// nearest fraction (to 1.0), the running hit flag and all control state.
module segment_triangle_nearest_hit_core #(
    parameter int COORD_BITS = stnh_pkg::CoordBitsDefault,
    parameter int T_BITS     = stnh_pkg::TBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    stnh_tri_if.sink    triangle,
    stnh_res_if.source  result
);
    import stnh_pkg::*;

    logic [COORD_BITS-1:0] seg_reg [NumRegs];
    cmd_t                  cmd;
    status_t               stat;

    stnh_regs #(.COORD_BITS(COORD_BITS)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seg_reg (seg_reg)
    );

    stnh_ctrl #(.T_BITS(T_BITS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (triangle.valid),
        .in_ready (triangle.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stnh_dp #(.COORD_BITS(COORD_BITS), .T_BITS(T_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg_reg  (seg_reg),
        .triangle (triangle),
        .result   (result),
        .cmd      (cmd),
        .stat     (stat)
    );
endmodule
